// ----- hdl/sgef_pkg.sv -----
// Shared types, register indexes and the Sobel kernel for the gradient energy block.
package sgef_pkg;

	localparam int unsigned CFG_W    = 13;
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned GRAD_W   = 11;
	localparam int unsigned SQ_W     = 20;
	localparam int unsigned ESUM4_W  = 23;
	localparam int unsigned SUM_W    = 45;
	localparam int unsigned MEAN_W   = 21;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned HDIM_W   = 13;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned DIV_STEPS  = SUM_W;
	localparam int unsigned DCNT_W     = 6;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_GRAD,
		ST_SQ,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} grad_t;

	// one pixel's gx/gy from the 3x3 neighbourhood (u/m/d rows, l/c/r cols)
	function automatic grad_t sobel(input logic [PIX_W-1:0] ul, input logic [PIX_W-1:0] uc,
			input logic [PIX_W-1:0] ur, input logic [PIX_W-1:0] ml,
			input logic [PIX_W-1:0] mr, input logic [PIX_W-1:0] dl,
			input logic [PIX_W-1:0] dc, input logic [PIX_W-1:0] dr);
		grad_t g;
		g.gx = (GRAD_W'(ur) - GRAD_W'(ul)) + ((GRAD_W'(mr) - GRAD_W'(ml)) <<< 1)
			+ (GRAD_W'(dr) - GRAD_W'(dl));
		g.gy = (GRAD_W'(ul) + (GRAD_W'(uc) <<< 1) + GRAD_W'(ur))
			- (GRAD_W'(dl) + (GRAD_W'(dc) <<< 1) + GRAD_W'(dr));
		return g;
	endfunction

endpackage

// ----- hdl/sobel_gradient_energy_focus.sv -----
// Top level: Tenengrad (3x3 Sobel gradient energy) focus measure over an RGB frame.
//
// Usage notes
//  - Input channel: red/green/blue with in_valid/in_stall; one request is one
//    pixel in raster order. Each pixel passes through accept, line buffer
//    read-modify-write, gradients, squares and accumulate in turn; the line
//    buffers are single-entry-per-pixel RMW memories, and the next pixel is
//    taken only once the accumulate step is done. After a frame's last
//    pixel the next one also waits for the divider.
//  - Output channel: energy_mean/energy_sum with out_valid/out_stall; one
//    request per frame, after the last pixel. The mean comes from a restoring
//    divider, one quotient bit a cycle.
//  - The result sits in an output register; pixels of the next frame are taken
//    while it waits. If it is still stalled when the next frame ends, the block
//    holds the new result and stops taking pixels until the old one is taken.
//  - Config: cfg_wr_en/cfg_index/cfg_data write frame_width (0) and
//    frame_height (1); reset values 640 and 480, clamped to legal range.
//  - Reset (arst_n low) clears counters, window, running sum and output valid.
//    Line buffers are not cleared: their stale entries are never used.
module sobel_gradient_energy_focus #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [0:0]                    cfg_index,
	input  logic [sgef_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sgef_pkg::PIX_W-1:0]    red,
	input  logic [sgef_pkg::PIX_W-1:0]    green,
	input  logic [sgef_pkg::PIX_W-1:0]    blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sgef_pkg::MEAN_W-1:0]   energy_mean,
	output logic [sgef_pkg::SUM_W-1:0]    energy_sum
);

	localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned DIV_W  = WDIM_W + sgef_pkg::HDIM_W;
	localparam int unsigned PW     = sgef_pkg::PIX_W;

	// configuration
	logic [sgef_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	logic [WDIM_W-1:0]          w_use;
	logic [sgef_pkg::HDIM_W-1:0] h_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sgef_pkg::CFG_W'(640);
			frame_height_q <= sgef_pkg::CFG_W'(480);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sgef_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				sgef_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < sgef_pkg::CFG_W'(2))
			w_use = WDIM_W'(2);
		else if (32'(frame_width_q) > MAX_WIDTH)
			w_use = WDIM_W'(MAX_WIDTH);
		else
			w_use = WDIM_W'(frame_width_q);
		if (frame_height_q < sgef_pkg::CFG_W'(2))
			h_use = sgef_pkg::HDIM_W'(2);
		else if (32'(frame_height_q) > sgef_pkg::MAX_HEIGHT)
			h_use = sgef_pkg::HDIM_W'(sgef_pkg::MAX_HEIGHT);
		else
			h_use = frame_height_q;
	end

	// control
	sgef_pkg::state_t state_q, state_d;
	logic accept, out_take, out_load;
	logic div_done;

	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// position and per-pixel flags, latched at accept
	logic [COL_W-1:0]           col_q;
	logic [sgef_pkg::ROW_W-1:0] row_q;
	logic [COL_W-1:0]           col_s1;
	logic last_col_in, last_row_in;
	logic last_col_s1, last_row_s1, first_row_s1, col_ge1_s1, col_one_s1, row_one_s1;
	logic [PW-1:0] gray_in, gray_s1;
	logic [15:0]   gray_acc;
	logic [DIV_W-1:0] area_s1;

	assign gray_acc = 16'(77 * 32'(red) + 150 * 32'(green) + 29 * 32'(blue) + 128);
	assign gray_in  = gray_acc[15:8];
	assign last_col_in = 32'(col_q) + 1 >= 32'(w_use);
	assign last_row_in = 32'(row_q) + 1 >= 32'(h_use);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!last_col_in) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row_in ? '0 : row_q + sgef_pkg::ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_q;
			gray_s1      <= gray_in;
			last_col_s1  <= last_col_in;
			last_row_s1  <= last_row_in;
			first_row_s1 <= (row_q == '0);
			row_one_s1   <= (row_q == sgef_pkg::ROW_W'(1));
			col_ge1_s1   <= (col_q != '0);
			col_one_s1   <= (col_q == COL_W'(1));
			area_s1      <= DIV_W'(w_use) * DIV_W'(h_use);
		end
	end

	// line buffers: read at accept, written back in the next cycle (ST_WIN)
	logic [PW-1:0] line_above [MAX_WIDTH];
	logic [PW-1:0] line_two_above [MAX_WIDTH];
	logic [PW-1:0] mid_rd_q, top_rd_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_q <= line_above[col_q];
			top_rd_q <= line_two_above[col_q];
		end
		if (state_q == sgef_pkg::ST_WIN) begin
			line_two_above[col_s1] <= mid_rd_q;
			line_above[col_s1]     <= gray_s1;
		end
	end

	// 3x3 window, [row][col], col 2 newest
	logic [PW-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
		end else if (state_q == sgef_pkg::ST_WIN) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= gray_s1;
		end
	end

	// gradients: up to four output pixels (two columns x two rows) per input
	logic [1:0] up_i, lf_i;
	sgef_pkg::grad_t g_d [4];
	sgef_pkg::grad_t g_s2 [4];
	logic [3:0] en_d, en_s2;

	assign up_i = row_one_s1 ? 2'd2 : 2'd0;
	assign lf_i = col_one_s1 ? 2'd2 : 2'd0;

	always_comb begin
		// column c-1, row r-1
		g_d[0] = sgef_pkg::sobel(win_q[up_i][lf_i], win_q[up_i][1], win_q[up_i][2],
			win_q[1][lf_i], win_q[1][2], win_q[2][lf_i], win_q[2][1], win_q[2][2]);
		// column c-1, last row reflected below
		g_d[1] = sgef_pkg::sobel(win_q[1][lf_i], win_q[1][1], win_q[1][2],
			win_q[2][lf_i], win_q[2][2], win_q[1][lf_i], win_q[1][1], win_q[1][2]);
		// last column reflected right, row r-1
		g_d[2] = sgef_pkg::sobel(win_q[up_i][1], win_q[up_i][2], win_q[up_i][1],
			win_q[1][1], win_q[1][1], win_q[2][1], win_q[2][2], win_q[2][1]);
		// corner: last column and last row
		g_d[3] = sgef_pkg::sobel(win_q[1][1], win_q[1][2], win_q[1][1],
			win_q[2][1], win_q[2][1], win_q[1][1], win_q[1][2], win_q[1][1]);
		en_d[0] = col_ge1_s1 && !first_row_s1;
		en_d[1] = col_ge1_s1 && last_row_s1;
		en_d[2] = col_ge1_s1 && last_col_s1 && !first_row_s1;
		en_d[3] = col_ge1_s1 && last_col_s1 && last_row_s1;
	end

	always_ff @(posedge clk) begin
		if (state_q == sgef_pkg::ST_GRAD) begin
			for (int i = 0; i < 4; i++)
				g_s2[i] <= g_d[i];
			en_s2 <= en_d;
		end
	end

	// squares
	logic [sgef_pkg::ESUM4_W-1:0] e_d, e_s3;
	logic signed [2*sgef_pkg::GRAD_W-1:0] px2 [4];
	logic signed [2*sgef_pkg::GRAD_W-1:0] py2 [4];

	always_comb begin
		e_d = '0;
		for (int i = 0; i < 4; i++) begin
			px2[i] = g_s2[i].gx * g_s2[i].gx;
			py2[i] = g_s2[i].gy * g_s2[i].gy;
			if (en_s2[i])
				e_d = e_d + sgef_pkg::ESUM4_W'(px2[i][sgef_pkg::SQ_W-1:0])
					+ sgef_pkg::ESUM4_W'(py2[i][sgef_pkg::SQ_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sgef_pkg::ST_SQ)
			e_s3 <= e_d;
	end

	// running sum and frame end
	logic [sgef_pkg::SUM_W-1:0] energy_total_q, total_next;
	logic frame_end;

	assign total_next = energy_total_q + sgef_pkg::SUM_W'(e_s3);
	assign frame_end  = last_col_s1 && last_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			energy_total_q <= '0;
		else if (state_q == sgef_pkg::ST_ACC)
			energy_total_q <= frame_end ? '0 : total_next;
	end

	// restoring divider: one quotient bit per cycle
	logic [DIV_W:0]               rem_q, trial;
	logic [sgef_pkg::SUM_W-1:0]   quo_q, sum_hold_q;
	logic [DIV_W-1:0]             divisor_q;
	logic [sgef_pkg::DCNT_W-1:0]  dcnt_q;
	logic                         qbit;

	assign trial    = {rem_q[DIV_W-1:0], quo_q[sgef_pkg::SUM_W-1]};
	assign qbit     = trial >= {1'b0, divisor_q};
	assign div_done = dcnt_q == sgef_pkg::DCNT_W'(sgef_pkg::DIV_STEPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (state_q == sgef_pkg::ST_ACC) begin
			dcnt_q <= '0;
		end else if (state_q == sgef_pkg::ST_DIV && !div_done) begin
			dcnt_q <= dcnt_q + sgef_pkg::DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sgef_pkg::ST_ACC && frame_end) begin
			rem_q      <= '0;
			quo_q      <= total_next;
			sum_hold_q <= total_next;
			divisor_q  <= area_s1;
		end else if (state_q == sgef_pkg::ST_DIV && !div_done) begin
			rem_q <= qbit ? trial - {1'b0, divisor_q} : trial;
			quo_q <= {quo_q[sgef_pkg::SUM_W-2:0], qbit};
		end
	end

	// output register
	logic out_valid_q;
	logic [sgef_pkg::MEAN_W-1:0] mean_q;
	logic [sgef_pkg::SUM_W-1:0]  sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q  <= sum_hold_q;
			mean_q <= (quo_q > sgef_pkg::SUM_W'({sgef_pkg::MEAN_W{1'b1}}))
				? {sgef_pkg::MEAN_W{1'b1}} : quo_q[sgef_pkg::MEAN_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign energy_mean = mean_q;
	assign energy_sum  = sum_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sgef_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			sgef_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = sgef_pkg::ST_WIN;
			end
			sgef_pkg::ST_WIN:  state_d = sgef_pkg::ST_GRAD;
			sgef_pkg::ST_GRAD: state_d = sgef_pkg::ST_SQ;
			sgef_pkg::ST_SQ:   state_d = sgef_pkg::ST_ACC;
			sgef_pkg::ST_ACC:
				state_d = frame_end ? sgef_pkg::ST_DIV : sgef_pkg::ST_IDLE;
			sgef_pkg::ST_DIV:
				if (div_done)
					state_d = sgef_pkg::ST_DONE;
			sgef_pkg::ST_DONE:
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = sgef_pkg::ST_IDLE;
				end
			default: state_d = sgef_pkg::ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_to_win: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == sgef_pkg::ST_WIN)
		else $error("pixel accepted but line buffer update not started");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sgef_pkg::ST_DIV |-> dcnt_q <= sgef_pkg::DCNT_W'(sgef_pkg::DIV_STEPS))
		else $error("divider step count overran");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == sgef_pkg::ST_DONE) && div_done)
		else $error("result loaded before division finished");

	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgef_pkg::ST_ACC && frame_end) |=> energy_total_q == '0)
		else $error("running sum not cleared at frame end");
`endif

endmodule
